>>> hdl/szkm_pkg.sv
// ----------------------------------------------------------------------------
// szkm_pkg: shared types and constants for the sampler zone key map
// Holds the item kinds, the controller states, the zone record and the
// command and status bundles that run between the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package szkm_pkg;

	localparam int NOTE_W = 7;
	localparam int VEL_W  = 8;
	localparam int KIND_W = 2;
	localparam int IDX_W  = 4;
	localparam int DIST_W = 8;

	localparam logic MODE_EXPLICIT = 1'b0;
	localparam logic MODE_NEAREST  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_CLEAR   = 2'd1,
		KIND_REBUILD = 2'd2,
		KIND_LOOKUP  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLEAR,
		ST_RB_INIT,
		ST_RB_SCAN,
		ST_RB_WRITE,
		ST_LK_READ,
		ST_LK_MASK,
		ST_LK_SCAN,
		ST_FINISH
	} state_t;

	// One entry of the zone table.
	typedef struct packed {
		logic [NOTE_W-1:0]       root;
		logic [NOTE_W-1:0]       lo_note;
		logic [NOTE_W-1:0]       hi_note;
		logic signed [VEL_W-1:0] lo_vel;
		logic signed [VEL_W-1:0] hi_vel;
	} zone_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic clear;
		logic zone_init;
		logic scan_issue;
		logic scan_lookup;
		logic map_wr;
		logic map_rd;
		logic mask_ld;
		logic res_ld;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic issue_done;
		logic busy;
		logic hit;
		logic note_last;
	} sts_t;

	// The reported zone index is the low bits of the zone number.
	function automatic logic [IDX_W-1:0] low_idx(input logic [6:0] v);
		return v[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/szkm_ctrl.sv
// ----------------------------------------------------------------------------
// szkm_ctrl: sequencing controller of the zone key map
// Decodes each accepted item and steps the datapath through load, clear,
// rebuild and lookup sequences; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module szkm_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [szkm_pkg::KIND_W-1:0]     kind,
	output logic                            out_valid,
	input  logic                            out_stall,
	output szkm_pkg::cmd_t                  cmd,
	input  szkm_pkg::sts_t                  sts
);
	import szkm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.res_ld | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (kind_t'(kind))
						KIND_LOAD:    state_d = ST_LOAD;
						KIND_CLEAR:   state_d = ST_CLEAR;
						KIND_REBUILD: state_d = ST_RB_INIT;
						KIND_LOOKUP:  state_d = ST_LK_READ;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_RB_INIT: begin
				cmd.zone_init = 1'b1;
				state_d       = ST_RB_SCAN;
			end
			ST_RB_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.issue_done && !sts.busy) begin
					state_d = ST_RB_WRITE;
				end
			end
			ST_RB_WRITE: begin
				cmd.map_wr = 1'b1;
				state_d    = sts.note_last ? ST_FINISH : ST_RB_INIT;
			end
			ST_LK_READ: begin
				cmd.map_rd = 1'b1;
				state_d    = ST_LK_MASK;
			end
			ST_LK_MASK: begin
				cmd.mask_ld   = 1'b1;
				cmd.zone_init = 1'b1;
				state_d       = ST_LK_SCAN;
			end
			ST_LK_SCAN: begin
				cmd.scan_issue  = 1'b1;
				cmd.scan_lookup = 1'b1;
				if (sts.hit || (sts.issue_done && !sts.busy)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result register frees up in the same cycle it is taken.
				if (!out_valid_q || !out_stall) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/szkm_dp.sv
// ----------------------------------------------------------------------------
// szkm_dp: datapath of the zone key map
// Zone table memory, per-note map memory with valid bits, the zone scan
// pipeline for rebuild and lookup, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module szkm_dp #(
	parameter int ZONES      = 16,
	parameter int NOTE_COUNT = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  szkm_pkg::cmd_t                    cmd,
	output szkm_pkg::sts_t                    sts,
	input  logic                              mode,
	input  logic [szkm_pkg::NOTE_W-1:0]       note,
	input  logic [szkm_pkg::NOTE_W-1:0]       velocity,
	input  logic [szkm_pkg::NOTE_W-1:0]       min_note,
	input  logic [szkm_pkg::NOTE_W-1:0]       max_note,
	input  logic signed [szkm_pkg::VEL_W-1:0] min_velocity,
	input  logic signed [szkm_pkg::VEL_W-1:0] max_velocity,
	output logic                              found,
	output logic [szkm_pkg::IDX_W-1:0]        zone_index,
	output logic                              status
);
	import szkm_pkg::*;

	localparam int ZAW = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int ZCW = $clog2(ZONES + 1);
	localparam int NAW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

	// Captured item fields.
	logic [NOTE_W-1:0] note_q;
	logic [NOTE_W-1:0] vel_q;
	zone_t             zin_q;

	// Zone table.
	zone_t             zone_mem [ZONES];
	zone_t             zone_rd_s1;
	logic [ZCW-1:0]    count_q;
	logic              room;

	// Zone scan.
	logic [ZCW-1:0]    zi_q;
	logic [ZAW-1:0]    z_s1;
	logic              rd_vld_s1;
	logic              issue;
	logic              hit_q;

	// Note map.
	logic [ZONES-1:0]      map_mem [NOTE_COUNT];
	logic [NOTE_COUNT-1:0] map_vld_q;
	logic [ZONES-1:0]      map_rd_s1;
	logic                  map_hit_s1;
	logic [NAW-1:0]        n_q;
	logic [ZONES-1:0]      acc_q;
	logic [DIST_W-1:0]     best_q;
	logic [ZONES-1:0]      mask_q;

	// Pending and delivered results.
	logic              pfound_q;
	logic [IDX_W-1:0]  pidx_q;
	logic              pstat_q;
	logic              found_q;
	logic [IDX_W-1:0]  idx_q;
	logic              stat_q;

	// Evaluation terms.
	logic [NOTE_W-1:0] rnote;
	logic [NOTE_W-1:0] root_gap;
	logic [DIST_W-1:0] dist_w;
	logic              in_range;
	logic [ZONES-1:0]  bit_z;
	logic              vel_ok;
	logic              single;
	logic              in_note;
	logic              rb_eval;
	logic              lk_hit;

	assign room    = (count_q < ZCW'(ZONES));
	assign issue   = cmd.scan_issue && (zi_q != count_q) && !hit_q;
	assign in_note = ({1'b0, note_q} < DIST_W'(NOTE_COUNT));

	always_comb begin
		rnote    = NOTE_W'(n_q);
		root_gap = (zone_rd_s1.root > rnote) ? (zone_rd_s1.root - rnote)
		                                     : (rnote - zone_rd_s1.root);
		dist_w   = {1'b0, root_gap};
		in_range = (rnote >= zone_rd_s1.lo_note) && (rnote <= zone_rd_s1.hi_note);
		bit_z    = ZONES'(1) << z_s1;
		vel_ok   = zone_rd_s1.lo_vel[VEL_W-1] || zone_rd_s1.hi_vel[VEL_W-1] ||
		           (($signed({1'b0, vel_q}) >= zone_rd_s1.lo_vel) &&
		            ($signed({1'b0, vel_q}) <= zone_rd_s1.hi_vel));
		single   = (mask_q != '0) && ((mask_q & (mask_q - ZONES'(1))) == '0);
		rb_eval  = rd_vld_s1 && cmd.scan_issue && !cmd.scan_lookup;
		lk_hit   = rd_vld_s1 && cmd.scan_lookup && !hit_q && mask_q[z_s1] &&
		           (single || vel_ok);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			zi_q      <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			map_vld_q <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.clear) begin
				count_q   <= '0;
				map_vld_q <= '0;
			end else begin
				if (cmd.load_wr && room) begin
					count_q <= count_q + ZCW'(1);
				end
				if (cmd.map_wr) begin
					map_vld_q[n_q] <= 1'b1;
				end
			end
			if (cmd.zone_init) begin
				zi_q  <= '0;
				hit_q <= 1'b0;
			end else begin
				if (issue) begin
					zi_q <= zi_q + ZCW'(1);
				end
				if (lk_hit) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Zone table memory.
	always_ff @(posedge clk) begin
		if (cmd.load_wr && room) begin
			zone_mem[count_q[ZAW-1:0]] <= zin_q;
		end
		if (issue) begin
			zone_rd_s1 <= zone_mem[zi_q[ZAW-1:0]];
		end
	end

	// Note map memory.
	always_ff @(posedge clk) begin
		if (cmd.map_wr) begin
			map_mem[n_q] <= acc_q;
		end
		if (cmd.map_rd) begin
			map_rd_s1 <= map_mem[note_q[NAW-1:0]];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			note_q        <= note;
			vel_q         <= velocity;
			zin_q.root    <= note;
			zin_q.lo_note <= min_note;
			zin_q.hi_note <= max_note;
			zin_q.lo_vel  <= min_velocity;
			zin_q.hi_vel  <= max_velocity;
			n_q           <= '0;
			pfound_q      <= 1'b0;
			pidx_q        <= '0;
			pstat_q       <= 1'b0;
		end
		if (issue) begin
			z_s1 <= zi_q[ZAW-1:0];
		end
		if (cmd.load_wr) begin
			if (room) begin
				pidx_q <= low_idx(7'(count_q));
			end else begin
				pstat_q <= 1'b1;
			end
		end
		if (cmd.zone_init) begin
			acc_q  <= '0;
			best_q <= DIST_W'(NOTE_COUNT);
		end else if (rb_eval) begin
			if (mode == MODE_EXPLICIT) begin
				if (in_range) begin
					acc_q <= acc_q | bit_z;
				end
			end else begin
				// Nearest root: a strictly closer zone restarts the set.
				if (dist_w < best_q) begin
					best_q <= dist_w;
					acc_q  <= bit_z;
				end else if (dist_w == best_q) begin
					acc_q <= acc_q | bit_z;
				end
			end
		end
		if (cmd.map_wr) begin
			n_q <= n_q + NAW'(1);
		end
		if (cmd.map_rd) begin
			map_hit_s1 <= in_note && map_vld_q[note_q[NAW-1:0]];
		end
		if (cmd.mask_ld) begin
			mask_q <= map_hit_s1 ? map_rd_s1 : '0;
		end
		if (lk_hit) begin
			pfound_q <= 1'b1;
			pidx_q   <= low_idx(7'(z_s1));
		end
		if (cmd.res_ld) begin
			found_q <= pfound_q;
			idx_q   <= pidx_q;
			stat_q  <= pstat_q;
		end
	end

	always_comb begin
		sts.issue_done = (zi_q == count_q);
		sts.busy       = rd_vld_s1;
		sts.hit        = hit_q;
		sts.note_last  = (n_q == NAW'(NOTE_COUNT - 1));
	end

	assign found      = found_q;
	assign zone_index = idx_q;
	assign status     = stat_q;

endmodule

`default_nettype wire

>>> hdl/sampler_zone_key_map.sv
// ----------------------------------------------------------------------------
// sampler_zone_key_map: key and velocity zone map of a sample player
// A load or clear writes or empties the zone table and then finishes; a lookup
// reads the note map, loads the zone mask and scans zones through the zone table
// read port (at most the loaded zone count); a rebuild scans every loaded zone
// for each of the NOTE_COUNT notes. One item is in work at a time.
// Reset clears the zone count, the map valid bits and the mode register.
// ----------------------------------------------------------------------------
`default_nettype none

module sampler_zone_key_map #(
	parameter int ZONES      = 16,
	parameter int NOTE_COUNT = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: the mode register, written whenever cfg_wr_en is high.
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [szkm_pkg::KIND_W-1:0]       kind,
	input  logic [szkm_pkg::NOTE_W-1:0]       note,
	input  logic [szkm_pkg::NOTE_W-1:0]       velocity,
	input  logic [szkm_pkg::NOTE_W-1:0]       min_note,
	input  logic [szkm_pkg::NOTE_W-1:0]       max_note,
	input  logic signed [szkm_pkg::VEL_W-1:0] min_velocity,
	input  logic signed [szkm_pkg::VEL_W-1:0] max_velocity,
	// Output channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [szkm_pkg::IDX_W-1:0]        zone_index,
	output logic                              status
);
	import szkm_pkg::*;

	// The mode is only looked at while a rebuild walks the notes, so it is a
	// plain register with no shadow copy.
	logic mode_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXPLICIT;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// The controller accepts a transfer only in its idle state. It can do so
	// while an earlier result still sits in the output register; the new
	// result then waits in the datapath's pending registers until that
	// register has been taken.
	szkm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the zone table and the per-note zone masks. Both a
	// rebuild and a lookup walk the loaded zones in load order through one
	// registered read port of the zone table; a lookup stops at the first
	// zone that qualifies.
	szkm_dp #(
		.ZONES      (ZONES),
		.NOTE_COUNT (NOTE_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode_q),
		.note         (note),
		.velocity     (velocity),
		.min_note     (min_note),
		.max_note     (max_note),
		.min_velocity (min_velocity),
		.max_velocity (max_velocity),
		.found        (found),
		.zone_index   (zone_index),
		.status       (status)
	);

endmodule

`default_nettype wire

>>> bench/sampler_zone_key_map_tb.sv
// ----------------------------------------------------------------------------
// sampler_zone_key_map_tb: self-checking bench for the sampler zone key map
// Sends zone loads, clears, map rebuilds and lookups through the input
// channel under random valid and stall gaps, predicts every answer from a
// zone table and note map kept on the bench side, and checks each result
// transfer field by field in order, in both explicit and nearest modes.
// ----------------------------------------------------------------------------
`default_nettype none

module sampler_zone_key_map_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import szkm_pkg::*;

	localparam int ZONES      = 16;
	localparam int NOTE_COUNT = 128;

	// One input item as it sits on the input channel.
	typedef struct packed {
		kind_t                   kind;
		logic [NOTE_W-1:0]       note;
		logic [NOTE_W-1:0]       velocity;
		logic [NOTE_W-1:0]       min_note;
		logic [NOTE_W-1:0]       max_note;
		logic signed [VEL_W-1:0] min_velocity;
		logic signed [VEL_W-1:0] max_velocity;
	} key_item_t;

	// One answer as it leaves the output channel.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] zone_index;
		logic             status;
	} answer_t;

	// All block inputs start at known values, before reset has any effect.
	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;
	logic      in_valid    = 1'b0;
	logic      out_stall   = 1'b0;
	key_item_t in_item     = '0;

	logic                 in_stall;
	logic                 out_valid;
	logic                 found;
	logic [IDX_W-1:0]     zone_index;
	logic                 status;

	// Bench-side copy of the block state, updated once per accepted item.
	logic                    mode_shadow;
	logic [4:0]              zone_total;
	zone_t                   zone_table [ZONES];
	logic [ZONES-1:0]        note_masks [NOTE_COUNT];

	key_item_t pending_items [$];
	answer_t   expected_answers [$];
	answer_t   next_answer;
	int        mismatches;
	int        results_seen;
	// While set, neither side of the bench inserts gaps or stalls.
	logic      calm;

	always #5 clk = ~clk;

	sampler_zone_key_map #(
		.ZONES      (ZONES),
		.NOTE_COUNT (NOTE_COUNT)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (in_item.kind),
		.note         (in_item.note),
		.velocity     (in_item.velocity),
		.min_note     (in_item.min_note),
		.max_note     (in_item.max_note),
		.min_velocity (in_item.min_velocity),
		.max_velocity (in_item.max_velocity),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.zone_index   (zone_index),
		.status       (status)
	);

	// Works out the answer to one accepted item and applies its effect on the
	// zone table and the note map. The mode is only consulted by a rebuild.
	function automatic answer_t predict_zone_answer(key_item_t it);
		answer_t          a;
		logic [ZONES-1:0] m;
		int               best;
		int               d;
		int               r;
		int               v;
		int               lo;
		int               hi;
		a = '0;
		case (it.kind)
			KIND_LOAD: begin
				// A full table keeps its contents and flags the load.
				if (zone_total >= ZONES) begin
					a.status = 1'b1;
				end else begin
					zone_table[zone_total] = '{root: it.note, lo_note: it.min_note,
						hi_note: it.max_note, lo_vel: it.min_velocity,
						hi_vel: it.max_velocity};
					a.zone_index = zone_total[IDX_W-1:0];
					zone_total = zone_total + 5'd1;
				end
			end
			KIND_CLEAR: begin
				zone_total = '0;
				for (int n = 0; n < NOTE_COUNT; n++)
					note_masks[n] = '0;
			end
			KIND_REBUILD: begin
				for (int n = 0; n < NOTE_COUNT; n++) begin
					m = '0;
					if (mode_shadow == MODE_EXPLICIT) begin
						// An inverted note range simply never matches.
						for (int z = 0; z < zone_total; z++)
							if (n >= zone_table[z].lo_note && n <= zone_table[z].hi_note)
								m[z] = 1'b1;
					end else begin
						// Every zone at the smallest root distance is mapped; the
						// search starts at NOTE_COUNT, so that distance never maps.
						best = NOTE_COUNT;
						for (int z = 0; z < zone_total; z++) begin
							r = zone_table[z].root;
							d = (r > n) ? r - n : n - r;
							if (d < best)
								best = d;
						end
						for (int z = 0; z < zone_total; z++) begin
							r = zone_table[z].root;
							d = (r > n) ? r - n : n - r;
							if (d == best)
								m[z] = 1'b1;
						end
					end
					note_masks[n] = m;
				end
			end
			default: begin
				m = note_masks[it.note];
				v = it.velocity;
				if (m != '0 && (m & (m - 1'b1)) == '0) begin
					// A lone mapped zone wins whatever the velocity.
					for (int z = 0; z < ZONES && !a.found; z++)
						if (m[z]) begin
							a.found = 1'b1;
							a.zone_index = z[IDX_W-1:0];
						end
				end else begin
					// First zone in load order that has no velocity range or
					// whose range holds the velocity.
					for (int z = 0; z < ZONES && !a.found; z++) begin
						lo = $signed(zone_table[z].lo_vel);
						hi = $signed(zone_table[z].hi_vel);
						if (m[z] && (lo < 0 || hi < 0 || (v >= lo && v <= hi))) begin
							a.found = 1'b1;
							a.zone_index = z[IDX_W-1:0];
						end
					end
				end
			end
		endcase
		return a;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
		mismatches++;
	endtask

	// Appends one item to the tail of the send queue.
	task automatic append_item(input key_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	// Appends one answer to the tail of the expectation queue.
	task automatic append_answer(input answer_t a);
		expected_answers.insert(expected_answers.size(), a);
	endtask

	// An item of the given kind with every other field drawn over its full width.
	function automatic key_item_t random_item(kind_t k);
		key_item_t it;
		it.kind         = k;
		it.note         = 7'($urandom_range(0, 127));
		it.velocity     = 7'($urandom_range(0, 127));
		it.min_note     = 7'($urandom_range(0, 127));
		it.max_note     = 7'($urandom_range(0, 127));
		it.min_velocity = 8'($urandom_range(0, 255));
		it.max_velocity = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic push_item(input kind_t k, input int nt, input int vel, input int lo_n,
		input int hi_n, input int lo_v, input int hi_v);
		key_item_t it;
		it.kind         = k;
		it.note         = 7'(nt);
		it.velocity     = 7'(vel);
		it.min_note     = 7'(lo_n);
		it.max_note     = 7'(hi_n);
		it.min_velocity = 8'(lo_v);
		it.max_velocity = 8'(hi_v);
		append_item(it);
	endtask

	// Holds the sender back until every queued item has been transferred and
	// every expected answer has come back. Checked on the falling edge so that
	// it never races the driver or the monitor.
	task automatic drain_results();
		while (pending_items.size() != 0 || in_valid || expected_answers.size() != 0)
			@(negedge clk);
	endtask

	// The mode register is only touched while the block is idle. Every item
	// produces a result, so an empty expectation queue means nothing is in work;
	// spare cycles let the block settle back into its idle state.
	task automatic settle_and_set_mode(input logic m);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		mode_shadow = m;
		@(negedge clk);
	endtask

	// Most of the random traffic is built as small songs: clear, load a few
	// zones, rebuild, then look up notes aimed at the zones just loaded. The
	// remainder is loose items of any kind with random content, which also
	// produces lookups before a rebuild and loads without one.
	task automatic plan_random_phase(input int budget);
		int        queued;
		int        k;
		int        looks;
		int        lo;
		int        hi;
		int        vb;
		key_item_t it;
		key_item_t layout [$];
		queued = 0;
		while (queued < budget) begin
			if ($urandom_range(0, 99) < 82) begin
				layout.delete();
				if ($urandom_range(0, 9) < 7) begin
					append_item(random_item(KIND_CLEAR));
					queued++;
				end
				// Small layouts keep rebuilds short; now and then the table fills
				// up or overflows.
				k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
				if ($urandom_range(0, 9) == 0)
					k = ZONES + $urandom_range(1, 3);
				for (int i = 0; i < k; i++) begin
					it = random_item(KIND_LOAD);
					if ($urandom_range(0, 9) == 0) begin
						lo = $urandom_range(1, 127);
						hi = $urandom_range(0, lo - 1);
					end else begin
						lo = $urandom_range(0, 127);
						hi = lo + $urandom_range(0, 40);
						if (hi > 127)
							hi = 127;
					end
					it.min_note = 7'(lo);
					it.max_note = 7'(hi);
					if ($urandom_range(0, 1) == 0)
						it.note = 7'($urandom_range(lo < hi ? lo : hi, lo < hi ? hi : lo));
					case ($urandom_range(0, 9))
						0, 1: begin
							it.min_velocity = -8'sd1;
							it.max_velocity = 8'($urandom_range(0, 127));
						end
						2: it.max_velocity = 8'h80 | 8'($urandom_range(0, 127));
						3: begin
							it.min_velocity = 8'h80 | 8'($urandom_range(0, 127));
							it.max_velocity = 8'h80 | 8'($urandom_range(0, 127));
						end
						4: begin
							lo = $urandom_range(1, 127);
							it.min_velocity = 8'(lo);
							it.max_velocity = 8'($urandom_range(0, lo - 1));
						end
						default: begin
							lo = $urandom_range(0, 127);
							it.min_velocity = 8'(lo);
							it.max_velocity = 8'(lo + $urandom_range(0, 127 - lo));
						end
					endcase
					append_item(it);
					layout.insert(layout.size(), it);
					queued++;
				end
				if ($urandom_range(0, 9) != 0) begin
					append_item(random_item(KIND_REBUILD));
					queued++;
				end
				looks = $urandom_range(3, 12);
				for (int i = 0; i < looks; i++) begin
					it = random_item(KIND_LOOKUP);
					if ($urandom_range(0, 9) < 7) begin
						// Aim at the edges of one loaded zone, where the
						// mapping and the velocity choice change.
						k = $urandom_range(0, layout.size() - 1);
						case ($urandom_range(0, 4))
							0: it.note = layout[k].note;
							1: it.note = layout[k].min_note;
							2: it.note = layout[k].max_note;
							3: it.note = layout[k].min_note - 7'd1;
							default: it.note = layout[k].max_note + 7'd1;
						endcase
						case ($urandom_range(0, 4))
							0: vb = $signed(layout[k].min_velocity);
							1: vb = $signed(layout[k].max_velocity);
							2: vb = $signed(layout[k].min_velocity) - 1;
							3: vb = $signed(layout[k].max_velocity) + 1;
							default: vb = $urandom_range(0, 127);
						endcase
						it.velocity = 7'(vb);
					end
					append_item(it);
					queued++;
				end
			end else begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					append_item(random_item(kind_t'($urandom_range(0, 3))));
				queued += k;
			end
		end
	endtask

	// Driver: a new item goes up only once the previous one has been
	// transferred, and a stalled item is held as it is. Each transfer is
	// predicted at the edge where it happens, so answers queue up in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				append_answer(predict_zone_answer(in_item));
			if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
				in_item  <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stalls the output at random and checks every result transfer
	// against the oldest waiting answer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					flag_mismatch($sformatf("no answer expected, got found=%0b zone=%0d status=%0b",
						found, zone_index, status));
				end else begin
					next_answer = expected_answers.pop_front();
					if (found !== next_answer.found)
						flag_mismatch($sformatf("found %0b, want %0b", found, next_answer.found));
					if (zone_index !== next_answer.zone_index)
						flag_mismatch($sformatf("zone_index %0d, want %0d", zone_index,
							next_answer.zone_index));
					if (status !== next_answer.status)
						flag_mismatch($sformatf("status %0b, want %0b", status, next_answer.status));
				end
				results_seen++;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 18);
		end
	end

	// Stimulus and the end of the run.
	initial begin
		mode_shadow  = MODE_EXPLICIT;
		zone_total   = '0;
		mismatches   = 0;
		results_seen = 0;
		calm         = 1'b0;
		for (int n = 0; n < NOTE_COUNT; n++)
			note_masks[n] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		settle_and_set_mode(MODE_EXPLICIT);
		// Lookup before any zone, then a load that stays unmapped until rebuilt.
		push_item(KIND_LOOKUP, 0, 0, 0, 0, 0, 0);
		push_item(KIND_LOAD, 60, 0, 0, 127, -1, -1);
		push_item(KIND_LOOKUP, 60, 0, 0, 0, 0, 0);
		push_item(KIND_REBUILD, 0, 0, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 127, 127, 0, 0, 0, 0);
		// Clear wipes the map as well as the table.
		push_item(KIND_CLEAR, 127, 127, 127, 127, 127, 127);
		push_item(KIND_LOOKUP, 127, 127, 0, 0, 0, 0);
		// An inverted note range, two overlapping zones split by velocity and
		// a zone whose negative upper bound lets any velocity through.
		push_item(KIND_LOAD, 0, 0, 127, 0, 0, 127);
		push_item(KIND_LOAD, 127, 0, 64, 127, 64, 127);
		push_item(KIND_LOAD, 100, 0, 64, 127, 0, 63);
		push_item(KIND_LOAD, 6, 0, 0, 10, 127, -128);
		push_item(KIND_REBUILD, 0, 0, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 127, 127, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 64, 0, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 5, 50, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 30, 0, 0, 0, 0, 0);

		// Nearest mode on the same zones: ties between equally distant roots
		// and lone nearest zones that ignore the velocity.
		settle_and_set_mode(MODE_NEAREST);
		push_item(KIND_REBUILD, 0, 0, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 3, 0, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 113, 127, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 53, 100, 0, 0, 0, 0);
		push_item(KIND_LOOKUP, 64, 127, 0, 0, 0, 0);

		// Random phases. Each mode change waits for the block to run dry,
		// which is also where the sender sits out until every answer is in.
		settle_and_set_mode(MODE_EXPLICIT);
		plan_random_phase(283);
		settle_and_set_mode(MODE_NEAREST);
		calm = 1'b1;
		plan_random_phase(283);
		settle_and_set_mode(MODE_EXPLICIT);
		calm = 1'b0;
		plan_random_phase(283);
		settle_and_set_mode(MODE_NEAREST);
		plan_random_phase(283);

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("sampler_zone_key_map_tb OK");
		else
			$display("sampler_zone_key_map_tb NOT OK");
		$finish;
	end

	// Watchdog, well beyond the slowest run of this stimulus, which is about a
	// hundred full-table rebuilds plus every lookup and stall gap.
	initial begin
		#(30_000_000);
		$display("sampler_zone_key_map_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
